/* src/lrupr_pkg.sv */
// Shared types and constants for the LRU page-frame table.
// Used by lrupr_cell and by the top level lru_page_replacement; no dependencies.
`default_nettype none

package lrupr_pkg;

  // Default sizing, handed down through the top-level parameters
  localparam int MaxFramesDef = 32;
  localparam int PageBitsDef  = 5;
  localparam int AgeBitsDef   = 16;

  // Fixed field widths of the configuration and result beats
  localparam int CfgBits      = 6;
  localparam int FaultBits    = 16;
  localparam int OutIdxBits   = 5;
  localparam int OutPageBits  = 5;
  localparam int OutDataBits  = 32;

  localparam logic [CfgBits-1:0]   FramesReset = CfgBits'(4);
  localparam logic [FaultBits-1:0] FaultMax    = '1;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPDT = 3'b100
  } lrupr_state_e;

  // Update command broadcast to every frame cell
  typedef struct packed {
    logic en;    // apply the decision this cycle
    logic fill;  // miss: write the requested page into the chosen frame
  } lrupr_upd_t;

endpackage

`default_nettype wire

/* src/lrupr_cell.sv */
// One frame cell of the LRU table: holds page, valid bit and age of one frame,
// and one stage of the search chain. Depends on lrupr_pkg.
`default_nettype none

module lrupr_cell import lrupr_pkg::*; #(
  parameter int IDX       = 0,
  parameter int PAGE_BITS = PageBitsDef,
  parameter int AGE_BITS  = AgeBitsDef,
  parameter int IW        = 5
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  active_i,
  input  wire [PAGE_BITS-1:0]  page_i,
  input  lrupr_upd_t           upd_i,
  input  wire [IW-1:0]         slot_i,
  // search token from the previous cell
  input  wire                  hit_i,
  input  wire [IW-1:0]         hit_idx_i,
  input  wire                  emp_i,
  input  wire [IW-1:0]         emp_idx_i,
  input  wire [AGE_BITS-1:0]   best_age_i,
  input  wire [IW-1:0]         best_idx_i,
  input  wire [PAGE_BITS-1:0]  best_page_i,
  // search token to the next cell
  output logic                 hit_o,
  output logic [IW-1:0]        hit_idx_o,
  output logic                 emp_o,
  output logic [IW-1:0]        emp_idx_o,
  output logic [AGE_BITS-1:0]  best_age_o,
  output logic [IW-1:0]        best_idx_o,
  output logic [PAGE_BITS-1:0] best_page_o
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic [AGE_BITS-1:0]  age_q, age_d;
  logic                 valid_d;
  logic [PAGE_BITS-1:0] page_d;

  logic                 hit_d, emp_d;
  logic [IW-1:0]        hit_idx_d, emp_idx_d, best_idx_d;
  logic [AGE_BITS-1:0]  best_age_d;
  logic [PAGE_BITS-1:0] best_page_d;

  // Fold this frame into the passing token; inactive frames pass it on
  always_comb begin
    hit_d       = hit_i;
    hit_idx_d   = hit_idx_i;
    emp_d       = emp_i;
    emp_idx_d   = emp_idx_i;
    best_age_d  = best_age_i;
    best_idx_d  = best_idx_i;
    best_page_d = best_page_i;
    if (active_i) begin
      if (!hit_i && valid_q && (page_q == page_i)) begin
        hit_d     = 1'b1;
        hit_idx_d = MyIdx;
      end
      if (!emp_i && !valid_q) begin
        emp_d     = 1'b1;
        emp_idx_d = MyIdx;
      end
      // later frames win ties
      if (age_q >= best_age_i) begin
        best_age_d  = age_q;
        best_idx_d  = MyIdx;
        best_page_d = page_q;
      end
    end
  end

  // Hand the token to the neighbor every cycle
  always_ff @(posedge clk_i) begin
    hit_o       <= hit_d;
    hit_idx_o   <= hit_idx_d;
    emp_o       <= emp_d;
    emp_idx_o   <= emp_idx_d;
    best_age_o  <= best_age_d;
    best_idx_o  <= best_idx_d;
    best_page_o <= best_page_d;
  end

  // Apply the decision: reset age of the chosen frame, age the other valid frames, saturating
  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    age_d   = age_q;
    if (upd_i.en && active_i) begin
      if (slot_i == MyIdx) begin
        age_d = '0;
        if (upd_i.fill) begin
          page_d  = page_i;
          valid_d = 1'b1;
        end
      end else if (valid_q && (age_q != '1)) begin
        age_d = age_q + AGE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

`default_nettype wire

/* src/lru_page_replacement.sv */
// Top level of the LRU page-frame table: sequencer, configuration register,
// fault counter, result register and the chain of lrupr_cell frames. Uses lrupr_pkg.
`default_nettype none

// Fully associative LRU page-frame table. Each input beat carries a page
// number; the result beat reports hit/miss, the frame that now holds the
// page, the evicted page if a resident one was replaced, and the saturating
// fault count. Frames are cells in a chain and a search token walks the
// chain one frame per cycle, collecting the first match, the first empty
// frame and the oldest frame. An access goes from accepting the page,
// through the token crossing the chain, to the update, which registers the
// result beat; a stalled result holds the update until the previous beat
// is taken. The finished result sits in an output register, so a new page is
// taken while the previous result waits. The user must write frames_in_use
// through the cfg channel only while the table is idle; the block itself
// does not enforce this. 0 acts as 1 and values above MAX_FRAMES act as
// MAX_FRAMES.
module lru_page_replacement import lrupr_pkg::*; #(
  parameter int MAX_FRAMES = MaxFramesDef,
  parameter int PAGE_BITS  = PageBitsDef,
  parameter int AGE_BITS   = AgeBitsDef,
  localparam int InDataBits = ((PAGE_BITS + 7) / 8) * 8
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // configuration: frames_in_use
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire [CfgBits-1:0]      cfg_data_i,
  // input beats
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire [InDataBits-1:0]   s_axis_tdata,  // page_number, zero fill
  // result beats
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  output logic [OutDataBits-1:0] m_axis_tdata   // hit, frame_index, evicted_valid,
                                                // evicted_page, fault_total, zero fill
);

  localparam int IW = $clog2(MAX_FRAMES);
  localparam int NW = $clog2(MAX_FRAMES + 1);

  lrupr_state_e         state_q, state_d;
  logic [IW-1:0]        cnt_q, cnt_d;
  logic [CfgBits-1:0]   frames_q;
  logic [NW-1:0]        active_n;
  logic [PAGE_BITS-1:0] page_q;
  logic [FaultBits-1:0] fault_q, fault_d;
  logic                 out_valid_q;
  logic [OutDataBits-1:0] out_data_q;

  logic s_fire, out_free, do_upd;

  // search chain, element 0 is the empty token
  logic                 ch_hit   [MAX_FRAMES+1];
  logic [IW-1:0]        ch_hidx  [MAX_FRAMES+1];
  logic                 ch_emp   [MAX_FRAMES+1];
  logic [IW-1:0]        ch_eidx  [MAX_FRAMES+1];
  logic [AGE_BITS-1:0]  ch_age   [MAX_FRAMES+1];
  logic [IW-1:0]        ch_bidx  [MAX_FRAMES+1];
  logic [PAGE_BITS-1:0] ch_bpage [MAX_FRAMES+1];

  logic [MAX_FRAMES-1:0] cell_act;
  lrupr_upd_t            upd;
  logic [IW-1:0]         slot;
  logic                  hit, ev_valid;
  logic [PAGE_BITS-1:0]  ev_page;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign do_upd        = (state_q == ST_UPDT) && out_free;

  // Hold the frame count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FramesReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frames_q <= cfg_data_i;
    end
  end

  // Clamp the frame count to 1..MAX_FRAMES
  always_comb begin
    if (frames_q == '0) begin
      active_n = NW'(1);
    end else if (int'(frames_q) > MAX_FRAMES) begin
      active_n = NW'(MAX_FRAMES);
    end else begin
      active_n = NW'(frames_q);
    end
  end

  // Sequence one access: accept, scan the chain, update
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == IW'(MAX_FRAMES - 1)) begin
          state_d = ST_UPDT;
        end
      end
      ST_UPDT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Latch the requested page for the whole access
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      page_q <= s_axis_tdata[PAGE_BITS-1:0];
    end
  end

  // Frame cells
  assign ch_hit[0]   = 1'b0;
  assign ch_hidx[0]  = '0;
  assign ch_emp[0]   = 1'b0;
  assign ch_eidx[0]  = '0;
  assign ch_age[0]   = '0;
  assign ch_bidx[0]  = '0;
  assign ch_bpage[0] = '0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    assign cell_act[g] = (NW'(g) < active_n);

    lrupr_cell #(
      .IDX       (g),
      .PAGE_BITS (PAGE_BITS),
      .AGE_BITS  (AGE_BITS),
      .IW        (IW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .active_i    (cell_act[g]),
      .page_i      (page_q),
      .upd_i       (upd),
      .slot_i      (slot),
      .hit_i       (ch_hit[g]),
      .hit_idx_i   (ch_hidx[g]),
      .emp_i       (ch_emp[g]),
      .emp_idx_i   (ch_eidx[g]),
      .best_age_i  (ch_age[g]),
      .best_idx_i  (ch_bidx[g]),
      .best_page_i (ch_bpage[g]),
      .hit_o       (ch_hit[g+1]),
      .hit_idx_o   (ch_hidx[g+1]),
      .emp_o       (ch_emp[g+1]),
      .emp_idx_o   (ch_eidx[g+1]),
      .best_age_o  (ch_age[g+1]),
      .best_idx_o  (ch_bidx[g+1]),
      .best_page_o (ch_bpage[g+1])
    );
  end

  // Pick the frame from the token leaving the last cell
  always_comb begin
    hit      = ch_hit[MAX_FRAMES];
    ev_valid = 1'b0;
    ev_page  = '0;
    if (hit) begin
      slot = ch_hidx[MAX_FRAMES];
    end else if (ch_emp[MAX_FRAMES]) begin
      slot = ch_eidx[MAX_FRAMES];
    end else begin
      slot     = ch_bidx[MAX_FRAMES];
      ev_valid = 1'b1;
      ev_page  = ch_bpage[MAX_FRAMES];
    end
    upd.en   = do_upd;
    upd.fill = !hit;
  end

  // Count faults, saturating
  always_comb begin
    fault_d = fault_q;
    if (!hit && (fault_q != FaultMax)) begin
      fault_d = fault_q + FaultBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q <= '0;
    end else if (do_upd) begin
      fault_q <= fault_d;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_upd) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_upd) begin
      out_data_q <= {4'b0000,
                     fault_d,
                     OutPageBits'(ev_page),
                     ev_valid,
                     OutIdxBits'(slot),
                     hit};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q == ST_SCAN))
    else $error("accepted page did not start a scan");

  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_UPDT))
    else $error("result beat appeared without an update");

  a_no_evict_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[6]))
    else $error("eviction reported on a hit");

  a_fault_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_UPDT) |=> $stable(fault_q))
    else $error("fault count moved outside an update");
`endif

endmodule

`default_nettype wire
